// File: src/bla_pkg.sv
package bla_pkg;

    // Ticket width and the saturation value of a ticket.
    localparam int TICKET_W = 32;
    localparam logic [TICKET_W-1:0] TICKET_MAX = '1;

    // Field widths of an item.
    localparam int TID_W = 4;

    // Command codes.
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Strobes from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;
        logic max_en;
        logic min_en;
    } scan_ctrl_t;

endpackage

// File: src/bla_cell.sv
module bla_cell
    import bla_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic [TICKET_W-1:0] ticket_in,
    output logic [TICKET_W-1:0] ticket_out
);

    logic [TICKET_W-1:0] ticket_reg;
    logic [TICKET_W-1:0] ticket_next;

    // The cell takes its neighbour's ticket whenever the ring steps.
    always_comb
    begin
        ticket_next = shift ? ticket_in : ticket_reg;
    end

    // A thread that has never acquired holds no ticket.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticket_reg <= '0;
        end
        else
        begin
            ticket_reg <= ticket_next;
        end
    end

    assign ticket_out = ticket_reg;

endmodule

// File: src/bla_scan.sv
module bla_scan
    import bla_pkg::*;
#(
    parameter int IDW = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  scan_ctrl_t          ctrl,
    input  logic [TICKET_W-1:0] ticket,
    input  logic [IDW-1:0]      id,
    output logic [TICKET_W-1:0] max_ticket,
    output logic                min_found,
    output logic [IDW-1:0]      min_id
);

    logic [TICKET_W-1:0] max_reg;
    logic [TICKET_W-1:0] max_next;
    logic [TICKET_W-1:0] min_reg;
    logic [TICKET_W-1:0] min_next;
    logic                found_reg;
    logic                found_next;
    logic [IDW-1:0]      min_id_reg;
    logic [IDW-1:0]      min_id_next;

    // Running maximum and running minimum of the nonzero tickets. Ids arrive
    // in ascending order, so a strict compare keeps the lowest id on a tie.
    always_comb
    begin
        max_next    = max_reg;
        min_next    = min_reg;
        found_next  = found_reg;
        min_id_next = min_id_reg;
        if (ctrl.clear)
        begin
            max_next    = '0;
            min_next    = '0;
            found_next  = 1'b0;
            min_id_next = '0;
        end
        else
        begin
            if (ctrl.max_en && (ticket > max_reg))
            begin
                max_next = ticket;
            end
            if (ctrl.min_en && (ticket != '0) && (!found_reg || (ticket < min_reg)))
            begin
                min_next    = ticket;
                found_next  = 1'b1;
                min_id_next = id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg    <= max_next;
        min_reg    <= min_next;
        min_id_reg <= min_id_next;
    end

    assign max_ticket = max_reg;
    assign min_found  = found_reg;
    assign min_id     = min_id_reg;

endmodule

// File: src/bakery_lock_arbiter.sv
// Bakery lock arbiter. The tickets of all threads sit in a ring of cells that
// steps by one place a cycle during a walk, past a single compare unit at its
// head. An acquire walks the ring once to find the largest ticket, then walks
// it again to write the new ticket and find the holder. A release, or an item
// whose thread id is not below THREADS, needs only the second walk. After the
// second walk the result is loaded into an output register, and only then can
// the next item be accepted. One item is in work at a time; the result waits
// in the output register, and the next item may be accepted while it is still
// stalled there.
module bakery_lock_arbiter
    import bla_pkg::*;
#(
    parameter int THREADS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [TID_W-1:0]    thread_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                requester_holds,
    output logic                holder_valid,
    output logic [TID_W-1:0]    holder_id,
    output logic [TICKET_W-1:0] ticket_given,
    output logic                ticket_saturated
);

    localparam int IDW  = $clog2(THREADS);
    localparam int CMPW = (IDW > TID_W) ? IDW : TID_W;
    localparam logic [IDW-1:0] LAST = IDW'(THREADS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAXP = 2'd1;
    localparam logic [1:0] ST_MINP = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [IDW-1:0]      cnt_reg;
    logic [IDW-1:0]      cnt_next;
    logic                cmd_reg;
    logic [TID_W-1:0]    tid_reg;
    logic                in_range_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                req_holds_reg;
    logic                hold_valid_reg;
    logic [TID_W-1:0]    hold_id_reg;
    logic [TICKET_W-1:0] given_reg;
    logic                sat_reg;

    logic                accept;
    logic                load_out;
    logic                in_range;
    logic                shift;
    logic                hit;
    logic                acq_active;
    logic                sat_w;
    logic [TICKET_W-1:0] given_w;
    logic [TICKET_W-1:0] head;
    logic [TICKET_W-1:0] feed;
    logic [TICKET_W-1:0] max_ticket;
    logic                min_found;
    logic [IDW-1:0]      min_id;
    logic [CMPW-1:0]     min_id_ext;
    scan_ctrl_t          scan_ctrl;
    logic [TICKET_W-1:0] ring [THREADS];

    // Handshake and item decode.
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_range = (32'(thread_id) < THREADS);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // New ticket from the largest one seen on the first walk.
    assign acq_active = (cmd_reg == CMD_ACQUIRE) && in_range_reg;
    assign sat_w      = acq_active && (max_ticket == TICKET_MAX);
    assign given_w    = !acq_active ? '0 : (sat_w ? TICKET_MAX : max_ticket + 1'b1);

    // The cell at the head holds the ticket of thread cnt_reg; on the second
    // walk the requester's ticket is replaced as it passes the head.
    assign head  = ring[0];
    assign shift = (state_reg == ST_MAXP) || (state_reg == ST_MINP);
    assign hit   = in_range_reg && (CMPW'(cnt_reg) == CMPW'(tid_reg));
    assign feed  = ((state_reg == ST_MINP) && hit) ? given_w : head;

    // Ring of ticket cells, each handing its ticket towards the head.
    genvar g;
    generate
        for (g = 0; g < THREADS; g++)
        begin : g_cell
            if (g == THREADS - 1)
            begin : g_tail
                bla_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift      (shift),
                    .ticket_in  (feed),
                    .ticket_out (ring[g])
                );
            end
            else
            begin : g_body
                bla_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift      (shift),
                    .ticket_in  (ring[g+1]),
                    .ticket_out (ring[g])
                );
            end
        end
    endgenerate

    // Strobes for the compare unit.
    always_comb
    begin
        scan_ctrl.clear  = accept;
        scan_ctrl.max_en = (state_reg == ST_MAXP);
        scan_ctrl.min_en = (state_reg == ST_MINP);
    end

    bla_scan #(
        .IDW (IDW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .ticket     (feed),
        .id         (cnt_reg),
        .max_ticket (max_ticket),
        .min_found  (min_found),
        .min_id     (min_id)
    );

    assign min_id_ext = CMPW'(min_id);

    // Sequencer: optional maximum walk, update-and-minimum walk, result.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = ((command == CMD_ACQUIRE) && in_range) ? ST_MAXP : ST_MINP;
                end
            end
            ST_MAXP:
            begin
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_MINP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MINP:
            begin
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item capture and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= command;
            tid_reg      <= thread_id;
            in_range_reg <= in_range;
        end
        if (load_out)
        begin
            req_holds_reg  <= in_range_reg && min_found
                              && (min_id_ext == CMPW'(tid_reg));
            hold_valid_reg <= min_found;
            hold_id_reg    <= min_found ? min_id_ext[TID_W-1:0] : '0;
            given_reg      <= given_w;
            sat_reg        <= sat_w;
        end
    end

    assign out_valid        = out_valid_reg;
    assign requester_holds  = req_holds_reg;
    assign holder_valid     = hold_valid_reg;
    assign holder_id        = hold_id_reg;
    assign ticket_given     = given_reg;
    assign ticket_saturated = sat_reg;

    // An accepted item always starts a ring walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MAXP || state_reg == ST_MINP))
        else $error("accepted item did not start a walk");

    // The maximum walk always hands over to the minimum walk from thread zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAXP && cnt_reg == LAST) |=> (state_reg == ST_MINP && cnt_reg == '0))
        else $error("maximum walk did not hand over to minimum walk");

    // A fresh result only appears after a completed walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");

    // A clamped ticket is always the top value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |-> (given_reg == TICKET_MAX))
        else $error("saturated ticket is not the maximum");

    // With no holder, nobody can be reported as holding the lock.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hold_valid_reg) |-> (!req_holds_reg && hold_id_reg == '0))
        else $error("holder reported without a valid holder");

endmodule
